@@ src/fpzmp_pkg.sv @@
// package for the foot pressure centre of pressure unit
// holds widths, request codes, controller states and the command/status structs
`timescale 1ns / 1ps
package fpzmp_pkg;
  localparam int SampleBitsDef = 16;
  localparam int CountBitsDef = 16;
  localparam int CfgBits = 40;
  localparam int IdxBits = 3;

  localparam logic [1:0] REQ_OFFSET  = 2'd0;
  localparam logic [1:0] REQ_MEASURE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [IdxBits-1:0] CFG_LSTEP  = 3'd0;
  localparam logic [IdxBits-1:0] CFG_RSTEP  = 3'd1;
  localparam logic [IdxBits-1:0] CFG_SDX    = 3'd2;
  localparam logic [IdxBits-1:0] CFG_SDY    = 3'd3;
  localparam logic [IdxBits-1:0] CFG_DFARY  = 3'd4;
  localparam logic [IdxBits-1:0] CFG_DNEARY = 3'd5;
  localparam logic [IdxBits-1:0] CFG_DDX    = 3'd6;

  localparam logic [39:0] LSTEP_RST = 40'd92461493288;
  localparam logic [39:0] RSTEP_RST = 40'd145096839270;

  localparam int KgFull = 20480;
  localparam int LightLimit = 819;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SENS_DIV, ST_SENS_WAIT, ST_SUMS, ST_COP_DIV, ST_COP_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;        // capture request
    logic offset_acc;  // add samples to sums
    logic clear;       // clear sums
    logic sens_start;  // start per-sensor work
    logic sens_next;   // store sensor result, move on
    logic sums;        // form loads and numerators
    logic cop_start;
    logic cop_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sens_last;
    logic cop_last;
  } status_t;
endpackage

@@ src/fpzmp_if.sv @@
// valid/ready channel interfaces for the foot pressure unit
// depends on fpzmp_pkg
`timescale 1ns / 1ps
interface fpzmp_in_if #(parameter int SAMPLE_BITS = fpzmp_pkg::SampleBitsDef);
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [SAMPLE_BITS-1:0] press_0, press_1, press_2, press_3;
  logic signed [SAMPLE_BITS-1:0] press_4, press_5, press_6, press_7;
  modport source (output valid, req_type, press_0, press_1, press_2, press_3,
                  press_4, press_5, press_6, press_7, input ready);
  modport sink (input valid, req_type, press_0, press_1, press_2, press_3,
                press_4, press_5, press_6, press_7, output ready);
endinterface

interface fpzmp_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] both_cop_x, both_cop_y, left_cop_x, left_cop_y;
  logic signed [23:0] right_cop_x, right_cop_y, left_torque_x, left_torque_y;
  logic [16:0] left_force, right_force;
  modport source (output valid, both_cop_x, both_cop_y, left_cop_x, left_cop_y,
                  right_cop_x, right_cop_y, left_force, right_force, left_torque_x,
                  left_torque_y, input ready);
  modport sink (input valid, both_cop_x, both_cop_y, left_cop_x, left_cop_y,
                right_cop_x, right_cop_y, left_force, right_force, left_torque_x,
                left_torque_y, output ready);
endinterface

@@ src/fpzmp_div.sv @@
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// no package dependencies
`timescale 1ns / 1ps
module fpzmp_div #(
  parameter int W = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q;
  logic [W-1:0] d;
  logic [W:0]   r;
  logic [CW-1:0] cnt;
  logic busy, neg;
  logic [W:0] trial;

  assign trial = {r[W-1:0], q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
        q <= num[W-1] ? W'(-num) : W'(num);
        d <= den[W-1] ? W'(-den) : W'(den);
        neg <= num[W-1] ^ den[W-1];
        r <= '0;
      end else if (busy) begin
        if (!trial[W]) begin
          r <= trial;
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= {r[W-1:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo = neg ? W'(-q) : W'(q);
endmodule

@@ src/fpzmp_ctrl.sv @@
// controller state machine for the foot pressure unit
// depends on fpzmp_pkg
`timescale 1ns / 1ps
module fpzmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_req,
  input  logic               cnt_full,
  input  logic               out_free,
  input  fpzmp_pkg::status_t sts,
  output logic               in_ready,
  output fpzmp_pkg::cmd_t    cmd
);
  fpzmp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fpzmp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpzmp_pkg::ST_IDLE:
        if (in_valid && in_req == fpzmp_pkg::REQ_MEASURE) state_next = fpzmp_pkg::ST_SENS_DIV;
      fpzmp_pkg::ST_SENS_DIV: state_next = fpzmp_pkg::ST_SENS_WAIT;
      fpzmp_pkg::ST_SENS_WAIT:
        if (sts.div_done) state_next = sts.sens_last ? fpzmp_pkg::ST_SUMS
                                                     : fpzmp_pkg::ST_SENS_DIV;
      fpzmp_pkg::ST_SUMS: state_next = fpzmp_pkg::ST_COP_DIV;
      fpzmp_pkg::ST_COP_DIV: state_next = fpzmp_pkg::ST_COP_WAIT;
      fpzmp_pkg::ST_COP_WAIT:
        if (sts.div_done) state_next = sts.cop_last ? fpzmp_pkg::ST_OUT
                                                    : fpzmp_pkg::ST_COP_DIV;
      fpzmp_pkg::ST_OUT: if (out_free) state_next = fpzmp_pkg::ST_IDLE;
      default: state_next = fpzmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      fpzmp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.offset_acc = in_valid && in_req == fpzmp_pkg::REQ_OFFSET && !cnt_full;
        cmd.clear = in_valid && in_req == fpzmp_pkg::REQ_CLEAR;
        cmd.sens_start = in_valid && in_req == fpzmp_pkg::REQ_MEASURE;
      end
      fpzmp_pkg::ST_SENS_DIV: ;
      fpzmp_pkg::ST_SENS_WAIT: cmd.sens_next = sts.div_done;
      fpzmp_pkg::ST_SUMS: cmd.sums = 1'b1;
      fpzmp_pkg::ST_COP_DIV: cmd.cop_start = 1'b1;
      fpzmp_pkg::ST_COP_WAIT: cmd.cop_next = sts.div_done;
      fpzmp_pkg::ST_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end
endmodule

@@ src/fpzmp_dp.sv @@
// datapath: offset sums, per-sensor scaling, loads, numerators, shared divider
// depends on fpzmp_pkg and fpzmp_div
`timescale 1ns / 1ps
module fpzmp_dp #(
  parameter int SAMPLE_BITS = fpzmp_pkg::SampleBitsDef,
  parameter int COUNT_BITS  = fpzmp_pkg::CountBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpzmp_pkg::cmd_t              cmd,
  output fpzmp_pkg::status_t           sts,
  output logic                         cnt_full,
  input  logic [SAMPLE_BITS*8-1:0]     press,
  input  logic [39:0]                  lstep,
  input  logic [39:0]                  rstep,
  input  logic signed [15:0]           sdx,
  input  logic signed [15:0]           sdy,
  input  logic signed [15:0]           dfary,
  input  logic signed [15:0]           dneary,
  input  logic signed [15:0]           ddx,
  output logic [24*8+17*2-1:0]         res
);
  localparam int DW = 56;
  localparam logic [30:0] Recip125 = 31'd1099511628;
  logic [31:0] sums [8];
  logic [COUNT_BITS-1:0] count;
  logic signed [SAMPLE_BITS-1:0] smp [8];
  logic [14:0] kg [8];
  logic [18:0] kx [8];
  logic [2:0] si;
  logic [3:0] ci;
  logic phase;             // 0 mean division, 1 kg division
  logic signed [DW-1:0] div_n, div_d, quo;
  logic div_start, div_done;
  logic signed [33:0] vdiff;
  logic kg_div, sens_more;
  logic [9:0] step;
  logic [16:0] lf, rf;
  logic [17:0] bf;
  logic signed [47:0] num [6];
  logic signed [23:0] cops [6];
  logic signed [23:0] tqo [2];
  logic [47:0] tq_abs [2];
  logic [47:0] tq_mul [2];
  logic [29:0] tq_m [2];
  logic tq_neg [2];
  logic [60:0] tq_p [2];
  logic signed [DW-1:0] tq_q [2];
  logic signed [18:0] ldx, ldy, rdx, rdy, bxs, bya, byb;
  logic signed [DW-1:0] cden;
  logic [17:0] cload;

  assign cnt_full = &count;
  assign step = si[2] ? rstep[10*si[1:0] +: 10] : lstep[10*si[1:0] +: 10];
  assign vdiff = 34'(smp[si]) - (count != '0 ? 34'(signed'(quo[33:0])) : 34'sd0);
  // clamped sample below four steps: scale it, otherwise full scale
  assign kg_div = vdiff[33] ? (step != 10'd0) : ($unsigned(vdiff) < {22'd0, step, 2'b00});
  assign sens_more = si != 3'd7;

  function automatic logic signed [23:0] sat(input logic signed [DW-1:0] x);
    if (x > DW'(8388607)) return 24'sh7fffff;
    if (x < -DW'(8388608)) return -24'sh800000;
    return x[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < 8; i++) sums[i] <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      for (int i = 0; i < 8; i++) sums[i] <= '0;
    end else if (cmd.offset_acc) begin
      count <= count + COUNT_BITS'(1);
      for (int i = 0; i < 8; i++)
        sums[i] <= sums[i] + 32'(signed'(press[i*SAMPLE_BITS +: SAMPLE_BITS]));
    end
  end

  // sensor loop (mean division per sensor, kg division only below four steps), sums and centre loop
  always_ff @(posedge clk) begin
    if (rst) begin
      si <= '0;
      ci <= '0;
      phase <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= cmd.sens_start || cmd.cop_start ||
                   (cmd.sens_next && ((!phase && kg_div) || sens_more));
      if (cmd.load)
        for (int i = 0; i < 8; i++) smp[i] <= press[i*SAMPLE_BITS +: SAMPLE_BITS];
      if (cmd.sens_start) begin
        si <= '0;
        phase <= 1'b0;
        div_n <= DW'(signed'(sums[0]));
        div_d <= DW'({1'b0, count});
      end
      if (cmd.sens_next) begin
        if (!phase) begin
          if (kg_div) begin
            phase <= 1'b1;
            div_n <= vdiff[33] ? '0 : DW'(vdiff) <<< 12;
            div_d <= DW'(step);
          end else begin
            kg[si] <= 15'(fpzmp_pkg::KgFull);
            si <= si + 1'b1;
            div_n <= DW'(signed'(sums[3'(si + 1'b1)]));
            div_d <= DW'({1'b0, count});
          end
        end else begin
          kg[si] <= quo[14:0];
          phase <= 1'b0;
          si <= si + 1'b1;
          div_n <= DW'(signed'(sums[3'(si + 1'b1)]));
          div_d <= DW'({1'b0, count});
        end
      end
      if (cmd.cop_next) begin
        ci <= ci + 1'b1;
        if (cload <= 18'(fpzmp_pkg::LightLimit)) cops[ci[2:0]] <= '0;
        else cops[ci[2:0]] <= sat(quo);
      end
      if (cmd.sums) begin
        ci <= '0;
        lf <= 17'(kx[0] + kx[1] + kx[2] + kx[3]);
        rf <= 17'(kx[4] + kx[5] + kx[6] + kx[7]);
        bf <= 18'(kx[0] + kx[1] + kx[2] + kx[3] + kx[4] + kx[5] + kx[6] + kx[7]);
        num[0] <= 48'(bxs) * 48'(ddx);
        num[1] <= 48'(bya) * 48'(dfary) + 48'(byb) * 48'(dneary);
        num[2] <= 48'(ldx) * 48'(sdx);
        num[3] <= 48'(ldy) * 48'(sdy);
        num[4] <= 48'(rdx) * 48'(sdx);
        num[5] <= 48'(rdy) * 48'(sdy);
      end
      if (cmd.cop_start) begin
        div_n <= DW'(num[ci[2:0]]) <<< 8;
        div_d <= cden;
      end
    end
  end

  // torques: |num|*49/8000 as (|num|*49 >> 6) / 125 by reciprocal multiply
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      tq_abs[j] = num[j+2][47] ? 48'(-num[j+2]) : 48'(num[j+2]);
      tq_mul[j] = tq_abs[j] * 48'd49;
      tq_p[j] = 61'(tq_m[j]) * 61'(Recip125);
      tq_q[j] = $signed({{(DW-24){1'b0}}, tq_p[j][60:37]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      tq_m[j] <= tq_mul[j][35:6];
      tq_neg[j] <= num[j+2][47];
      tqo[j] <= sat(tq_neg[j] ? -tq_q[j] : tq_q[j]);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) kx[i] = 19'(kg[i]);
  end

  assign ldx = kx[0] + kx[1] - kx[2] - kx[3];
  assign ldy = kx[0] + kx[3] - kx[1] - kx[2];
  assign rdx = kx[4] + kx[5] - kx[6] - kx[7];
  assign rdy = kx[4] + kx[7] - kx[5] - kx[6];
  assign bxs = kx[0] + kx[1] + kx[4] + kx[5] - kx[2] - kx[3] - kx[6] - kx[7];
  assign bya = kx[0] + kx[3] - kx[5] - kx[6];
  assign byb = kx[1] + kx[2] - kx[4] - kx[7];

  always_comb begin
    cload = bf;
    case (ci)
      4'd2, 4'd3: cload = 18'(lf);
      4'd4, 4'd5: cload = 18'(rf);
      default: cload = bf;
    endcase
    cden = DW'(cload);
  end

  fpzmp_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(quo)
  );

  assign sts.div_done = div_done;
  assign sts.sens_last = (si == 3'd7) && (phase || !kg_div);
  assign sts.cop_last = ci == 4'd5;
  assign res = {cops[0], cops[1], cops[2], cops[3], cops[4], cops[5],
                lf, rf, tqo[0], tqo[1]};
endmodule

@@ src/foot_pressure_zmp_calculator_unit.sv @@
// top level of the foot pressure centre of pressure unit
// depends on fpzmp_pkg, fpzmp_if, fpzmp_ctrl, fpzmp_dp
//
// in channel: one request per handshake: offset sample, measurement or clear
// out channel: one result per measurement request, none for the other codes
// offset, clear and unused requests leave the controller idle, so the next
// request can be taken on the following cycle
// a measurement runs 8 to 16 divisions on a shared bit-serial divider (a mean
// and a scaling division per sensor, no scaling division for a sensor at full
// scale), then six centre divisions; torques come from a constant reciprocal
// multiply alongside
// the result register is loaded as the controller leaves its output state,
// and no new measurement request is taken before that
// one request at a time: in.ready is high only while the controller is idle
// results sit in an output register; a stalled receiver holds the
// controller in its output state until the register is free
// reset clears offset sums, count, and restores default step tables
// configuration is to be written only while the unit is idle; the unit itself does not enforce this
`timescale 1ns / 1ps
module foot_pressure_zmp_calculator_unit #(
  parameter int SAMPLE_BITS = fpzmp_pkg::SampleBitsDef,
  parameter int COUNT_BITS  = fpzmp_pkg::CountBitsDef
) (
  input  logic                              clk,
  input  logic                              rst,
  fpzmp_in_if.sink                          in_ch,
  fpzmp_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [fpzmp_pkg::IdxBits-1:0]     cfg_idx,
  input  logic [fpzmp_pkg::CfgBits-1:0]     cfg_data
);
  fpzmp_pkg::cmd_t cmd;
  fpzmp_pkg::status_t sts;
  logic cnt_full, out_free;
  logic [39:0] lstep, rstep;
  logic signed [15:0] sdx, sdy, dfary, dneary, ddx;
  logic [24*8+17*2-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lstep <= fpzmp_pkg::LSTEP_RST;
      rstep <= fpzmp_pkg::RSTEP_RST;
      sdx <= '0; sdy <= '0; dfary <= '0; dneary <= '0; ddx <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fpzmp_pkg::CFG_LSTEP:  lstep <= cfg_data;
        fpzmp_pkg::CFG_RSTEP:  rstep <= cfg_data;
        fpzmp_pkg::CFG_SDX:    sdx <= cfg_data[15:0];
        fpzmp_pkg::CFG_SDY:    sdy <= cfg_data[15:0];
        fpzmp_pkg::CFG_DFARY:  dfary <= cfg_data[15:0];
        fpzmp_pkg::CFG_DNEARY: dneary <= cfg_data[15:0];
        fpzmp_pkg::CFG_DDX:    ddx <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_ch.valid || out_ch.ready;

  fpzmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_req(in_ch.req_type),
    .cnt_full(cnt_full), .out_free(out_free), .sts(sts),
    .in_ready(in_ch.ready), .cmd(cmd)
  );

  fpzmp_dp #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cnt_full(cnt_full),
    .press({in_ch.press_7, in_ch.press_6, in_ch.press_5, in_ch.press_4,
            in_ch.press_3, in_ch.press_2, in_ch.press_1, in_ch.press_0}),
    .lstep(lstep), .rstep(rstep), .sdx(sdx), .sdy(sdy), .dfary(dfary),
    .dneary(dneary), .ddx(ddx), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (cmd.out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      {out_ch.both_cop_x, out_ch.both_cop_y, out_ch.left_cop_x, out_ch.left_cop_y,
       out_ch.right_cop_x, out_ch.right_cop_y, out_ch.left_force, out_ch.right_force,
       out_ch.left_torque_x, out_ch.left_torque_y} <= res;
  end

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free) else $error("result register overwritten");
  // no request taken while a result is pending in the controller
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !in_ch.ready) else $error("request accepted mid measurement");
  // offsets never accumulate past a full count
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.offset_acc |-> !cnt_full) else $error("offset count overflow");
endmodule
